// ===== design/clr_pkg.sv =====
`default_nettype none
package clr_pkg;

    localparam int LINE_DEPTH = 256;
    localparam int ADDR_W     = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;

    localparam int JQ_DEPTH = 4;
    localparam int JQ_PW    = $clog2(JQ_DEPTH);
    localparam int OQ_DEPTH = 4;
    localparam int OQ_PW    = $clog2(OQ_DEPTH);

    localparam logic [1:0] CMD_RX    = 2'd0;
    localparam logic [1:0] CMD_READ  = 2'd1;
    localparam logic [1:0] CMD_CLEAR = 2'd2;

    localparam logic [7:0] BYTE_CR = 8'h0d;
    localparam logic [7:0] BYTE_LF = 8'h0a;

    // one classified transaction handed from the front to the back
    typedef struct packed {
        logic              wr;
        logic              rd;
        logic [ADDR_W-1:0] addr;
        logic [7:0]        data;
        logic              done;
        logic              cr;
        logic [7:0]        len;
    } t_job;

    typedef struct packed {
        logic       done;
        logic       cr;
        logic [7:0] len;
        logic [7:0] rbyte;
    } t_result;

endpackage
`default_nettype wire

// ===== design/crlf_line_receiver_unit.sv =====
// a transaction passes the job queue, the read stage and the result queue before its result is out
// throughput: one transaction per cycle while neither queue stalls, set by the single store port in the back end
// a 4-entry queue between front and back and a 4-entry result queue absorb stalls
// reset is synchronous and active low: clears line status, fill count and both queues
// the line store itself is not cleared and holds stale bytes until written
`default_nettype none
module crlf_line_receiver_unit (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_push,
    output logic            o_full,
    input  wire logic [1:0] i_cmd,
    input  wire logic [7:0] i_rx_byte,
    input  wire logic [7:0] i_read_index,
    input  wire logic       i_pop,
    output logic            o_empty,
    output logic            o_line_done,
    output logic            o_cr_pending,
    output logic [7:0]      o_line_length,
    output logic [7:0]      o_read_byte
);

    logic             job_push;
    clr_pkg::t_job    front_job;
    logic             q_valid;
    clr_pkg::t_job    q_job;
    logic             q_pop;
    clr_pkg::t_result result;

    clr_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (i_push),
        .i_cmd        (i_cmd),
        .i_rx_byte    (i_rx_byte),
        .i_read_index (i_read_index),
        .i_q_full     (o_full),
        .o_job_push   (job_push),
        .o_job        (front_job)
    );

    clr_job_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (job_push),
        .i_job   (front_job),
        .o_full  (o_full),
        .o_valid (q_valid),
        .o_job   (q_job),
        .i_pop   (q_pop)
    );

    clr_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (q_valid),
        .i_job       (q_job),
        .o_job_pop   (q_pop),
        .i_pop       (i_pop),
        .o_empty     (o_empty),
        .o_result    (result)
    );

    assign o_line_done   = result.done;
    assign o_cr_pending  = result.cr;
    assign o_line_length = result.len;
    assign o_read_byte   = result.rbyte;

endmodule
`default_nettype wire

// ===== design/clr_front.sv =====
`default_nettype none
module clr_front (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire logic [1:0]    i_cmd,
    input  wire logic [7:0]    i_rx_byte,
    input  wire logic [7:0]    i_read_index,
    input  wire logic          i_q_full,
    output logic               o_job_push,
    output clr_pkg::t_job      o_job
);

    logic                       r_done;
    logic                       r_cr;
    logic [clr_pkg::ADDR_W-1:0] r_fill;
    logic                       n_done;
    logic                       n_cr;
    logic [clr_pkg::ADDR_W-1:0] n_fill;
    logic                       accept;

    assign accept     = i_push & ~i_q_full;
    assign o_job_push = accept;

    always_comb begin
        n_done     = r_done;
        n_cr       = r_cr;
        n_fill     = r_fill;
        o_job.wr   = 1'b0;
        o_job.rd   = 1'b0;
        o_job.addr = r_fill;
        o_job.data = i_rx_byte;
        case (i_cmd)
            clr_pkg::CMD_RX: begin
                if (!r_done) begin
                    if (r_cr) begin
                        if (i_rx_byte == clr_pkg::BYTE_LF) begin
                            n_done = 1'b1;
                        end else begin
                            // broken terminator restarts the line
                            n_cr   = 1'b0;
                            n_fill = '0;
                        end
                    end else if (i_rx_byte == clr_pkg::BYTE_CR) begin
                        n_cr = 1'b1;
                    end else begin
                        o_job.wr = 1'b1;
                        if (r_fill == clr_pkg::ADDR_W'(clr_pkg::LINE_DEPTH - 1)) begin
                            n_fill = '0;
                        end else begin
                            n_fill = r_fill + 1'b1;
                        end
                    end
                end
            end
            clr_pkg::CMD_READ: begin
                o_job.rd   = (32'(i_read_index) < clr_pkg::LINE_DEPTH);
                o_job.addr = clr_pkg::ADDR_W'(i_read_index);
            end
            clr_pkg::CMD_CLEAR: begin
                n_done = 1'b0;
                n_cr   = 1'b0;
                n_fill = '0;
            end
            default: begin
            end
        endcase
        o_job.done = n_done;
        o_job.cr   = n_cr;
        o_job.len  = 8'(n_fill);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
            r_cr   <= 1'b0;
            r_fill <= '0;
        end else if (accept) begin
            r_done <= n_done;
            r_cr   <= n_cr;
            r_fill <= n_fill;
        end
    end

endmodule
`default_nettype wire

// ===== design/clr_job_queue.sv =====
`default_nettype none
module clr_job_queue (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire clr_pkg::t_job i_job,
    output logic               o_full,
    output logic               o_valid,
    output clr_pkg::t_job      o_job,
    input  wire logic          i_pop
);

    clr_pkg::t_job              r_q [clr_pkg::JQ_DEPTH];
    logic [clr_pkg::JQ_PW-1:0]  r_wp;
    logic [clr_pkg::JQ_PW-1:0]  r_rp;
    logic [clr_pkg::JQ_PW:0]    r_cnt;
    logic                       do_push;
    logic                       do_pop;

    assign o_full  = (r_cnt == (clr_pkg::JQ_PW + 1)'(clr_pkg::JQ_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_job   = r_q[r_rp];
    assign do_push = i_push & ~o_full;
    assign do_pop  = i_pop & o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) r_wp <= r_wp + 1'b1;
            if (do_pop) r_rp <= r_rp + 1'b1;
            case ({do_push, do_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) r_q[r_wp] <= i_job;
    end

endmodule
`default_nettype wire

// ===== design/clr_back.sv =====
`default_nettype none
module clr_back (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_job_valid,
    input  wire clr_pkg::t_job i_job,
    output logic               o_job_pop,
    input  wire logic          i_pop,
    output logic               o_empty,
    output clr_pkg::t_result   o_result
);

    logic [7:0]                r_store [clr_pkg::LINE_DEPTH];
    logic [7:0]                r_rdata;
    logic                      r_s1_valid;
    logic                      r_s1_rd;
    logic                      r_s1_done;
    logic                      r_s1_cr;
    logic [7:0]                r_s1_len;

    clr_pkg::t_result          r_oq [clr_pkg::OQ_DEPTH];
    logic [clr_pkg::OQ_PW-1:0] r_oq_wp;
    logic [clr_pkg::OQ_PW-1:0] r_oq_rp;
    logic [clr_pkg::OQ_PW:0]   r_oq_cnt;
    logic                      take;
    logic                      oq_pop;
    clr_pkg::t_result          s1_result;

    // credit check counts the transaction still in the read stage
    assign take      = i_job_valid &&
                       ((32'(r_oq_cnt) + 32'(r_s1_valid)) < clr_pkg::OQ_DEPTH);
    assign o_job_pop = take;
    assign o_empty   = (r_oq_cnt == '0);
    assign oq_pop    = i_pop & ~o_empty;
    assign o_result  = r_oq[r_oq_rp];

    always_comb begin
        s1_result.done  = r_s1_done;
        s1_result.cr    = r_s1_cr;
        s1_result.len   = r_s1_len;
        s1_result.rbyte = r_s1_rd ? r_rdata : 8'd0;
    end

    always_ff @(posedge i_clk) begin
        if (take && i_job.wr) r_store[i_job.addr] <= i_job.data;
        if (take && i_job.rd) r_rdata <= r_store[i_job.addr];
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_s1_rd   <= i_job.rd;
            r_s1_done <= i_job.done;
            r_s1_cr   <= i_job.cr;
            r_s1_len  <= i_job.len;
        end
        if (r_s1_valid) r_oq[r_oq_wp] <= s1_result;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_oq_wp    <= '0;
            r_oq_rp    <= '0;
            r_oq_cnt   <= '0;
        end else begin
            r_s1_valid <= take;
            if (r_s1_valid) r_oq_wp <= r_oq_wp + 1'b1;
            if (oq_pop) r_oq_rp <= r_oq_rp + 1'b1;
            case ({r_s1_valid, oq_pop})
                2'b10:   r_oq_cnt <= r_oq_cnt + 1'b1;
                2'b01:   r_oq_cnt <= r_oq_cnt - 1'b1;
                default: r_oq_cnt <= r_oq_cnt;
            endcase
        end
    end

endmodule
`default_nettype wire

// ===== design/clr_checker.sv =====
`default_nettype none
module clr_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       i_push,
    input wire logic       o_full,
    input wire logic       i_pop,
    input wire logic       o_empty,
    input wire logic       o_line_done,
    input wire logic       o_cr_pending,
    input wire logic [7:0] o_line_length,
    input wire logic [7:0] o_read_byte
);

    // no result survives reset
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> o_empty)
        else $error("result queue not empty after reset");

    a_reset_not_full: assert property (@(posedge i_clk) !i_rst_n |=> !o_full)
        else $error("input side full after reset");

    // a completed line always came through a pending cr
    a_done_has_cr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_empty && o_line_done) |-> o_cr_pending)
        else $error("line done without cr pending");

    a_hold_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_empty && !i_pop) |=> (!o_empty && $stable(o_line_done) &&
        $stable(o_cr_pending) && $stable(o_line_length) && $stable(o_read_byte)))
        else $error("waiting result changed or vanished");

endmodule

bind crlf_line_receiver_unit clr_checker u_clr_checker (.*);
`default_nettype wire
